/* rtl/bmwd_pkg.sv */
`default_nettype none

package bmwd_pkg;

   localparam int MAX_OUT_COLS = 65536;
   localparam int ADDR_W       = $clog2(MAX_OUT_COLS);
   localparam int DIM_W        = 16;
   localparam int FAC_W        = 7;
   localparam int STRIDE_W     = 2 * FAC_W - 1;
   localparam int PHASE_W      = 12;
   localparam int IDX_W        = 3;

   localparam logic [IDX_W-1:0] REG_IMAGE_COLS = 3'd0;
   localparam logic [IDX_W-1:0] REG_IMAGE_ROWS = 3'd1;
   localparam logic [IDX_W-1:0] REG_LOOK_ROWS  = 3'd2;
   localparam logic [IDX_W-1:0] REG_LOOK_COLS  = 3'd3;
   localparam logic [IDX_W-1:0] REG_SKIP_ROWS  = 3'd4;
   localparam logic [IDX_W-1:0] REG_SKIP_COLS  = 3'd5;

   typedef struct packed {
      logic             mask;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
      logic             last;
   } res_type;

   // look / skip factor: zero reads as one, anything above 64 as 64
   function automatic logic [FAC_W-1:0] clamp_factor(input logic [FAC_W-1:0] v);
      logic [FAC_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = FAC_W'(1);
      end else if (v > FAC_W'(64)) begin
         r = FAC_W'(64);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/bmwd_ram.sv */
`default_nettype none

module bmwd_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/binary_mask_window_downsampler.sv */
`default_nettype none

// Throughput: one item per cycle while not stalled, set by the single read-modify-write
// of the row store (read issued at acceptance, written back the next cycle, forwarded on
// back-to-back hits). Window results pass the read-modify-write stage and output register.
// Reset: synchronous; clears position counters and output stages, sets all CSRs to 1.
// The row store is not cleared: every entry is written on the first pixel of its window.
module binary_mask_window_downsampler
   import bmwd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [IDX_W-1:0]   csr_index,
   input  wire logic [DIM_W-1:0]   csr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_mask_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_mask_out,
   output logic      [DIM_W-1:0]   rsp_out_row,
   output logic      [DIM_W-1:0]   rsp_out_col,
   output logic                    rsp_last_of_image
);

   // configuration
   logic [DIM_W-1:0] image_cols_ff, image_rows_ff;
   logic [FAC_W-1:0] look_rows_ff, look_cols_ff, skip_rows_ff, skip_cols_ff;

   // position counters
   logic [DIM_W-1:0]   in_row_ff, in_col_ff, block_row_ff, block_col_ff;
   logic [DIM_W-1:0]   row_base_ff, col_base_ff;
   logic [PHASE_W-1:0] row_phase_ff, col_phase_ff;
   logic [DIM_W-1:0]   in_row_in, in_col_in, block_row_in, block_col_in;
   logic [DIM_W-1:0]   row_base_in, col_base_in;
   logic [PHASE_W-1:0] row_phase_in, col_phase_in;

   // read-modify-write stage
   logic             s1_valid_ff, s1_fwd_ff, s1_fwd_data_ff;
   logic             s1_pix_ff, s1_first_ff, s1_emit_ff, s1_last_ff;
   logic [DIM_W-1:0] s1_row_ff, s1_col_ff;

   // output register and skid
   logic    out_valid_ff, skid_valid_ff;
   res_type out_ff, skid_ff;

   logic [DIM_W-1:0]    ncols, nrows;
   logic [FAC_W-1:0]    lr, lc;
   logic [STRIDE_W-1:0] sr, sc;
   logic                row_fit, col_fit, row_last, col_last, in_window;
   logic                first_px, emit_px;
   logic                accept, depart, res_valid, col_end, row_end;
   logic [1:0]          occupancy;
   logic                rd_bit, old_bit, wr_bit;
   res_type             res;

   assign ncols = (image_cols_ff == '0) ? DIM_W'(1) : image_cols_ff;
   assign nrows = (image_rows_ff == '0) ? DIM_W'(1) : image_rows_ff;
   assign lr    = clamp_factor(look_rows_ff);
   assign lc    = clamp_factor(look_cols_ff);
   assign sr    = {{(STRIDE_W-FAC_W){1'b0}}, lr} *
                  {{(STRIDE_W-FAC_W){1'b0}}, clamp_factor(skip_rows_ff)};
   assign sc    = {{(STRIDE_W-FAC_W){1'b0}}, lc} *
                  {{(STRIDE_W-FAC_W){1'b0}}, clamp_factor(skip_cols_ff)};

   // a block counts only if its whole stride lies in the image and block_col < MAX_OUT_COLS
   assign row_fit  = ({1'b0, row_base_ff} + {{(DIM_W+1-STRIDE_W){1'b0}}, sr})
                     <= {1'b0, nrows};
   assign col_fit  = (({1'b0, col_base_ff} + {{(DIM_W+1-STRIDE_W){1'b0}}, sc})
                      <= {1'b0, ncols})
                     && ({1'b0, block_col_ff} < (DIM_W+1)'(MAX_OUT_COLS));
   assign row_last = ({2'b0, row_base_ff} + {{(DIM_W+1-STRIDE_W){1'b0}}, sr, 1'b0})
                     > {2'b0, nrows};
   assign col_last = (({2'b0, col_base_ff} + {{(DIM_W+1-STRIDE_W){1'b0}}, sc, 1'b0})
                      > {2'b0, ncols})
                     || ({2'b0, block_col_ff} + (DIM_W+2)'(1)
                         >= (DIM_W+2)'(MAX_OUT_COLS));

   assign in_window = row_fit && col_fit
                      && ({1'b0, row_phase_ff} < {{(PHASE_W+1-FAC_W){1'b0}}, lr})
                      && ({1'b0, col_phase_ff} < {{(PHASE_W+1-FAC_W){1'b0}}, lc});
   assign first_px  = (row_phase_ff == '0) && (col_phase_ff == '0);
   assign emit_px   = in_window
                      && ({1'b0, row_phase_ff} + (PHASE_W+1)'(1)
                          == {{(PHASE_W+1-FAC_W){1'b0}}, lr})
                      && ({1'b0, col_phase_ff} + (PHASE_W+1)'(1)
                          == {{(PHASE_W+1-FAC_W){1'b0}}, lc});

   // handshake: out + skid + pending result minus departing one must leave a slot
   assign depart    = out_valid_ff && !rsp_stall;
   assign res_valid = s1_valid_ff && s1_emit_ff;
   assign occupancy = 2'(out_valid_ff) + 2'(skid_valid_ff) + 2'(res_valid) - 2'(depart);
   assign req_stall = occupancy > 2'd1;
   assign accept    = req_valid && !req_stall;

   // next position
   assign col_end = ({1'b0, in_col_ff} + (DIM_W+1)'(1)) >= {1'b0, ncols};
   assign row_end = ({1'b0, in_row_ff} + (DIM_W+1)'(1)) >= {1'b0, nrows};

   always_comb begin
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff + DIM_W'(1);
      block_row_in = block_row_ff;
      block_col_in = block_col_ff;
      row_base_in  = row_base_ff;
      col_base_in  = col_base_ff;
      row_phase_in = row_phase_ff;
      col_phase_in = col_phase_ff + PHASE_W'(1);
      if (col_end) begin
         in_col_in    = '0;
         col_phase_in = '0;
         block_col_in = '0;
         col_base_in  = '0;
         if (row_end) begin
            in_row_in    = '0;
            row_phase_in = '0;
            block_row_in = '0;
            row_base_in  = '0;
         end else begin
            in_row_in = in_row_ff + DIM_W'(1);
            if (({1'b0, row_phase_ff} + (PHASE_W+1)'(1)) >= sr) begin
               row_phase_in = '0;
               block_row_in = block_row_ff + DIM_W'(1);
               row_base_in  = row_base_ff + {{(DIM_W-STRIDE_W){1'b0}}, sr};
            end else begin
               row_phase_in = row_phase_ff + PHASE_W'(1);
            end
         end
      end else if (({1'b0, col_phase_ff} + (PHASE_W+1)'(1)) >= sc) begin
         col_phase_in = '0;
         block_col_in = block_col_ff + DIM_W'(1);
         col_base_in  = col_base_ff + {{(DIM_W-STRIDE_W){1'b0}}, sc};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_cols_ff <= DIM_W'(1);
         image_rows_ff <= DIM_W'(1);
         look_rows_ff  <= FAC_W'(1);
         look_cols_ff  <= FAC_W'(1);
         skip_rows_ff  <= FAC_W'(1);
         skip_cols_ff  <= FAC_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            REG_IMAGE_COLS: image_cols_ff <= csr_data;
            REG_IMAGE_ROWS: image_rows_ff <= csr_data;
            REG_LOOK_ROWS:  look_rows_ff  <= csr_data[FAC_W-1:0];
            REG_LOOK_COLS:  look_cols_ff  <= csr_data[FAC_W-1:0];
            REG_SKIP_ROWS:  skip_rows_ff  <= csr_data[FAC_W-1:0];
            REG_SKIP_COLS:  skip_cols_ff  <= csr_data[FAC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (csr_write && (csr_index <= REG_SKIP_COLS))) begin
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         block_row_ff <= '0;
         block_col_ff <= '0;
         row_base_ff  <= '0;
         col_base_ff  <= '0;
         row_phase_ff <= '0;
         col_phase_ff <= '0;
      end else if (accept) begin
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         block_row_ff <= block_row_in;
         block_col_ff <= block_col_in;
         row_base_ff  <= row_base_in;
         col_base_ff  <= col_base_in;
         row_phase_ff <= row_phase_in;
         col_phase_ff <= col_phase_in;
      end
   end

   // row store: read at acceptance, written back in the cycle after
   bmwd_ram #(
      .WIDTH (1),
      .DEPTH (MAX_OUT_COLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff[ADDR_W-1:0]),
      .wr_data (wr_bit),
      .rd_en   (accept),
      .rd_addr (block_col_ff[ADDR_W-1:0]),
      .rd_data (rd_bit)
   );

   assign old_bit = s1_fwd_ff ? s1_fwd_data_ff : rd_bit;
   assign wr_bit  = s1_first_ff ? s1_pix_ff : (old_bit | s1_pix_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && in_window;
      end
      if (accept) begin
         s1_fwd_ff      <= s1_valid_ff && (s1_col_ff == block_col_ff);
         s1_fwd_data_ff <= wr_bit;
         s1_pix_ff      <= req_mask_in;
         s1_first_ff    <= first_px;
         s1_emit_ff     <= emit_px;
         s1_last_ff     <= row_last && col_last;
         s1_row_ff      <= block_row_ff;
         s1_col_ff      <= block_col_ff;
      end
   end

   assign res.mask = wr_bit;
   assign res.row  = s1_row_ff;
   assign res.col  = s1_col_ff;
   assign res.last = s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (depart) begin
            out_ff        <= skid_ff;
            skid_ff       <= res;
            skid_valid_ff <= res_valid;
         end
      end else if (!out_valid_ff || depart) begin
         out_ff       <= res;
         out_valid_ff <= res_valid;
      end else if (res_valid) begin
         skid_ff       <= res;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_mask_out      = out_ff.mask;
   assign rsp_out_row       = out_ff.row;
   assign rsp_out_col       = out_ff.col;
   assign rsp_last_of_image = out_ff.last;

endmodule

`default_nettype wire
